### rtl/srt_pkg.sv
// Shared types and constants for the selective-repeat receive tracker.
// No dependencies; every other file imports this package.
package srt_pkg;

  localparam int SEQ_W     = 16;
  localparam int LEN_W     = 16;
  localparam int WIN_W     = 13;
  localparam int BYTES_W   = 32;
  localparam int TOTAL_W   = 13;
  localparam int TIMER_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam logic [TOTAL_W-1:0] TOTAL_RST = 13'd1;
  localparam logic [LEN_W-1:0]   FULL_RST  = 16'd1024;
  localparam logic [LEN_W-1:0]   FINAL_RST = 16'd1024;
  localparam logic [TIMER_W-1:0] GAP_RST   = 16'd5000;
  localparam logic [TIMER_W-1:0] TIMER_SAT = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_ACK  = 2'd0,
    KIND_NACK = 2'd1,
    KIND_DONE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_GOOD = 2'd1,
    CMD_BAD  = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOTAL = 2'd0,
    CFG_FULL  = 2'd1,
    CFG_FINAL = 2'd2,
    CFG_GAP   = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_LOOK,
    B_MARK,
    B_SCAN,
    B_CHK,
    B_EMIT
  } back_state_e;

  typedef struct packed {
    cmd_e             cmd;
    logic [SEQ_W-1:0] seq;
    logic [LEN_W-1:0] len;
  } cmd_t;

  typedef struct packed {
    kind_e              kind;
    logic [SEQ_W-1:0]   seq;
    logic [WIN_W-1:0]   base;
    logic [BYTES_W-1:0] bytes;
    logic               last;
  } result_t;

endpackage

### rtl/srt_front.sv
// Front end: accepts input items, drops malformed data, classifies the rest.
// Depends on srt_pkg; feeds srt_fifo.
module srt_front import srt_pkg::*; #(
  parameter int MAX_PACKETS = 4096,
  localparam int CNT_W = $clog2(MAX_PACKETS + 1)
) (
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             operation_i,
  input  logic [SEQ_W-1:0] seq_in_i,
  input  logic [LEN_W-1:0] length_in_i,
  input  logic             crc_ok_i,
  input  logic             session_ok_i,
  input  logic [CNT_W-1:0] limit_i,
  input  logic [LEN_W-1:0] full_len_i,
  input  logic [LEN_W-1:0] final_len_i,
  input  logic             clearing_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output cmd_t             q_cmd_o
);

  logic [31:0]      seq32;
  logic [31:0]      lim32;
  logic [LEN_W-1:0] expected;
  logic             data_ok;
  logic             accept;

  assign seq32    = 32'(seq_in_i);
  assign lim32    = 32'(limit_i);
  assign expected = (seq32 == lim32 - 32'd1) ? final_len_i : full_len_i;

  assign data_ok = session_ok_i && (seq32 < lim32) && (length_in_i != '0) &&
                   (length_in_i <= full_len_i) && (length_in_i == expected);

  assign in_ready_o = !clearing_i && !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign q_push_o   = accept && (operation_i || data_ok);

  always_comb begin
    q_cmd_o.seq = seq_in_i;
    q_cmd_o.len = length_in_i;
    if (operation_i) begin
      q_cmd_o.cmd = CMD_TICK;
    end else if (crc_ok_i) begin
      q_cmd_o.cmd = CMD_GOOD;
    end else begin
      q_cmd_o.cmd = CMD_BAD;
    end
  end

endmodule

### rtl/srt_fifo.sv
// Short command queue between front end and back end.
// Depends on srt_pkg for the command type.
module srt_fifo import srt_pkg::*; #(
  parameter int DEPTH = 4,
  localparam int PW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t din_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t dout_o,
  output logic empty_o
);

  cmd_t          mem_q [DEPTH];
  logic [PW-1:0] wr_q, wr_d;
  logic [PW-1:0] rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign dout_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= din_i;
    end
  end

endmodule

### rtl/srt_back.sv
// Back end: received bitmap, counters, window-base scan and result sequencing.
// Depends on srt_pkg; drains srt_fifo and drives the result register.
module srt_back import srt_pkg::*; #(
  parameter int MAX_PACKETS = 4096,
  localparam int IDX_W = $clog2(MAX_PACKETS),
  localparam int CNT_W = $clog2(MAX_PACKETS + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [CNT_W-1:0]   limit_i,
  input  logic [TIMER_W-1:0] gap_i,
  input  logic               q_empty_i,
  input  cmd_t               q_cmd_i,
  output logic               q_pop_o,
  output logic               clearing_o,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output result_t            res_o
);

  logic map_mem [MAX_PACKETS];
  logic map_rd_q;
  logic mem_we;
  logic mem_wdata;
  logic [IDX_W-1:0] mem_addr;

  back_state_e state_q, state_d;
  logic [IDX_W-1:0]   clr_q, clr_d;
  logic [CNT_W-1:0]   base_q, base_d;
  logic [IDX_W-1:0]   high_q, high_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [BYTES_W-1:0] bytes_q, bytes_d;
  logic [TIMER_W-1:0] timer_q, timer_d;
  logic               fin_q, fin_d;
  logic               new_q, new_d;
  logic               p_ack_q, p_ack_d;
  logic               p_nack_q, p_nack_d;
  logic               p_done_q, p_done_d;
  logic               res_valid_q, res_valid_d;
  logic [SEQ_W-1:0]   seq_q, seq_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic [SEQ_W-1:0]   nseq_q, nseq_d;
  result_t            res_q, res_d;

  logic [31:0]      seq_ext, head_ext, base_ext;
  logic [IDX_W-1:0] seq_idx, head_idx, base_idx, base_nxt_idx;
  logic [CNT_W-1:0] base_inc;
  logic [32:0]      bsum;
  logic             base_lt, adv, slot_free, one_left;

  assign seq_ext      = 32'(seq_q);
  assign head_ext     = 32'(q_cmd_i.seq);
  assign base_ext     = 32'(base_q);
  assign seq_idx      = seq_ext[IDX_W-1:0];
  assign head_idx     = head_ext[IDX_W-1:0];
  assign base_idx     = base_q[IDX_W-1:0];
  assign base_inc     = base_q + CNT_W'(1);
  assign base_nxt_idx = base_inc[IDX_W-1:0];
  assign bsum         = {1'b0, bytes_q} + 33'(len_q);
  assign base_lt      = (base_q < limit_i);
  assign adv          = new_q && base_lt && map_rd_q;
  assign slot_free    = !res_valid_q || res_ready_i;
  assign one_left     = ($countones({p_ack_q, p_nack_q, p_done_q}) == 1);

  assign clearing_o  = (state_q == B_CLEAR);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_CLEAR: begin
        if (clr_q == IDX_W'(MAX_PACKETS - 1)) state_d = B_IDLE;
      end
      B_IDLE: begin
        if (!q_empty_i && !fin_q) begin
          case (q_cmd_i.cmd)
            CMD_GOOD: state_d = B_LOOK;
            CMD_BAD:  state_d = B_EMIT;
            default:  state_d = B_IDLE;
          endcase
        end
      end
      B_LOOK:  state_d = map_rd_q ? B_SCAN : B_MARK;
      B_MARK:  state_d = B_SCAN;
      B_SCAN:  state_d = B_CHK;
      B_CHK: begin
        if (!adv) state_d = B_EMIT;
      end
      B_EMIT: begin
        if (slot_free && one_left) state_d = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    clr_d       = clr_q;
    base_d      = base_q;
    high_d      = high_q;
    cnt_d       = cnt_q;
    bytes_d     = bytes_q;
    timer_d     = timer_q;
    fin_d       = fin_q;
    new_d       = new_q;
    p_ack_d     = p_ack_q;
    p_nack_d    = p_nack_q;
    p_done_d    = p_done_q;
    seq_d       = seq_q;
    len_d       = len_q;
    nseq_d      = nseq_q;
    res_d       = res_q;
    res_valid_d = res_valid_q && !res_ready_i;
    mem_we      = 1'b0;
    mem_wdata   = 1'b0;
    mem_addr    = base_idx;
    q_pop_o     = 1'b0;
    case (state_q)
      B_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_q;
        clr_d    = clr_q + IDX_W'(1);
      end
      B_IDLE: begin
        mem_addr = head_idx;
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          case (q_cmd_i.cmd)
            CMD_TICK: begin
              if (timer_q != TIMER_SAT) timer_d = timer_q + TIMER_W'(1);
            end
            CMD_GOOD: begin
              seq_d = q_cmd_i.seq;
              len_d = q_cmd_i.len;
            end
            CMD_BAD: begin
              if (!fin_q) begin
                p_nack_d = 1'b1;
                nseq_d   = q_cmd_i.seq;
              end
            end
            default: ;
          endcase
        end
      end
      B_LOOK: begin
        new_d = !map_rd_q;
      end
      B_MARK: begin
        mem_we    = 1'b1;
        mem_wdata = 1'b1;
        mem_addr  = seq_idx;
        cnt_d     = cnt_q + CNT_W'(1);
        bytes_d   = bsum[32] ? '1 : bsum[BYTES_W-1:0];
        if (seq_idx > high_q) high_d = seq_idx;
      end
      B_SCAN: begin
        mem_addr = base_idx;
      end
      B_CHK: begin
        mem_addr = base_nxt_idx;
        if (adv) begin
          base_d = base_inc;
        end else begin
          p_ack_d = 1'b1;
          if (base_lt && (base_ext <= 32'(high_q)) && !map_rd_q && (timer_q >= gap_i)) begin
            p_nack_d = 1'b1;
            nseq_d   = base_ext[SEQ_W-1:0];
            timer_d  = '0;
          end
          if (cnt_q >= limit_i) begin
            p_done_d = 1'b1;
            fin_d    = 1'b1;
          end
        end
      end
      B_EMIT: begin
        if (slot_free) begin
          res_valid_d = 1'b1;
          res_d.base  = base_ext[WIN_W-1:0];
          res_d.bytes = bytes_q;
          res_d.last  = one_left;
          if (p_ack_q) begin
            res_d.kind = KIND_ACK;
            res_d.seq  = seq_q;
            p_ack_d    = 1'b0;
          end else if (p_nack_q) begin
            res_d.kind = KIND_NACK;
            res_d.seq  = nseq_q;
            p_nack_d   = 1'b0;
          end else begin
            res_d.kind = KIND_DONE;
            res_d.seq  = '0;
            p_done_d   = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      clr_q       <= '0;
      base_q      <= '0;
      high_q      <= '0;
      cnt_q       <= '0;
      bytes_q     <= '0;
      timer_q     <= TIMER_SAT;
      fin_q       <= 1'b0;
      new_q       <= 1'b0;
      p_ack_q     <= 1'b0;
      p_nack_q    <= 1'b0;
      p_done_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      base_q      <= base_d;
      high_q      <= high_d;
      cnt_q       <= cnt_d;
      bytes_q     <= bytes_d;
      timer_q     <= timer_d;
      fin_q       <= fin_d;
      new_q       <= new_d;
      p_ack_q     <= p_ack_d;
      p_nack_q    <= p_nack_d;
      p_done_q    <= p_done_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seq_q  <= seq_d;
    len_q  <= len_d;
    nseq_q <= nseq_d;
    res_q  <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      map_mem[mem_addr] <= mem_wdata;
    end
    map_rd_q <= map_mem[mem_addr];
  end

endmodule

### rtl/selective_repeat_receive_tracker.sv
// Top level of the selective-repeat receive tracker: configuration registers,
// front end, command queue and back end. Depends on srt_pkg, srt_front,
// srt_fifo and srt_back.
//
//   channel   handshake              payload
//   input     in_valid_i/in_ready_o  operation_i seq_in_i length_in_i crc_ok_i session_ok_i
//   result    out_valid_o/out_ready_i kind_o seq_number_o window_base_o bytes_total_o last_o
//   config    cfg_valid_i/cfg_ready_o cfg_index_i cfg_data_i
//
// Tick: handled in the back-end idle state. Bad CRC: idle, then emit for its result.
// Good packet: idle, look, mark (skipped for a repeat), scan, then check again for each entry
// the window base advances, then emit once per result; the bitmap memory port sets these steps,
// one access a cycle.
// After reset a clearing pass writes every bitmap entry; no item is taken.
// The queue of QUEUE_DEPTH commands keeps input flowing while results stall.
module selective_repeat_receive_tracker import srt_pkg::*; #(
  parameter int MAX_PACKETS = 4096,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 operation_i,
  input  logic [SEQ_W-1:0]     seq_in_i,
  input  logic [LEN_W-1:0]     length_in_i,
  input  logic                 crc_ok_i,
  input  logic                 session_ok_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           kind_o,
  output logic [SEQ_W-1:0]     seq_number_o,
  output logic [WIN_W-1:0]     window_base_o,
  output logic [BYTES_W-1:0]   bytes_total_o,
  output logic                 last_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i
);

  localparam int CNT_W = $clog2(MAX_PACKETS + 1);

  logic [TOTAL_W-1:0] total_q;
  logic [LEN_W-1:0]   full_q;
  logic [LEN_W-1:0]   final_q;
  logic [TIMER_W-1:0] gap_q;
  logic [31:0]        tot32;
  logic [31:0]        lim32;
  logic [CNT_W-1:0]   limit;

  logic    clearing;
  logic    q_full, q_empty, q_push, q_pop;
  cmd_t    q_din, q_dout;
  result_t res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= TOTAL_RST;
      full_q  <= FULL_RST;
      final_q <= FINAL_RST;
      gap_q   <= GAP_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_TOTAL: total_q <= cfg_data_i[TOTAL_W-1:0];
        CFG_FULL:  full_q  <= cfg_data_i;
        CFG_FINAL: final_q <= cfg_data_i;
        CFG_GAP:   gap_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign tot32 = 32'(total_q);

  always_comb begin
    if (total_q == '0) begin
      lim32 = 32'd1;
    end else if (tot32 > 32'(MAX_PACKETS)) begin
      lim32 = 32'(MAX_PACKETS);
    end else begin
      lim32 = tot32;
    end
  end

  assign limit = lim32[CNT_W-1:0];

  srt_front #(
    .MAX_PACKETS(MAX_PACKETS)
  ) u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .seq_in_i    (seq_in_i),
    .length_in_i (length_in_i),
    .crc_ok_i    (crc_ok_i),
    .session_ok_i(session_ok_i),
    .limit_i     (limit),
    .full_len_i  (full_q),
    .final_len_i (final_q),
    .clearing_i  (clearing),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_cmd_o     (q_din)
  );

  srt_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .din_i  (q_din),
    .full_o (q_full),
    .pop_i  (q_pop),
    .dout_o (q_dout),
    .empty_o(q_empty)
  );

  srt_back #(
    .MAX_PACKETS(MAX_PACKETS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .limit_i    (limit),
    .gap_i      (gap_q),
    .q_empty_i  (q_empty),
    .q_cmd_i    (q_dout),
    .q_pop_o    (q_pop),
    .clearing_o (clearing),
    .res_valid_o(out_valid_o),
    .res_ready_i(out_ready_i),
    .res_o      (res)
  );

  assign kind_o        = res.kind;
  assign seq_number_o  = res.seq;
  assign window_base_o = res.base;
  assign bytes_total_o = res.bytes;
  assign last_o        = res.last;

endmodule

### tb/sv/srt_checker.sv
// Scoreboard for the selective-repeat receive tracker: watches the input, result and
// register channels, predicts ACK/NACK/DONE replies and compares them in order.
// Depends on srt_pkg.
module srt_checker import srt_pkg::*; #(
  parameter int MAX_PACKETS = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic                 operation_i,
  input  logic [SEQ_W-1:0]     seq_in_i,
  input  logic [LEN_W-1:0]     length_in_i,
  input  logic                 crc_ok_i,
  input  logic                 session_ok_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [1:0]           kind_i,
  input  logic [SEQ_W-1:0]     seq_number_i,
  input  logic [WIN_W-1:0]     window_base_i,
  input  logic [BYTES_W-1:0]   bytes_total_i,
  input  logic                 last_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  cfg_idx_e             cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  output int                   errors_o,
  output int                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic                             seen_map [MAX_PACKETS];
  logic [WIN_W-1:0]                 base_q;
  logic [$clog2(MAX_PACKETS)-1:0]   highest_q;
  logic [TOTAL_W-1:0]               unique_q;
  logic [BYTES_W-1:0]               bytes_q;
  logic [TIMER_W-1:0]               nack_timer;
  logic                             finished_q;
  logic [TOTAL_W-1:0]               reg_total;
  logic [LEN_W-1:0]                 reg_full;
  logic [LEN_W-1:0]                 reg_last_len;
  logic [TIMER_W-1:0]               reg_gap;
  result_t                          due_replies [$];
  int                               mismatches = 0;
  int                               waiting = 0;

  assign errors_o  = mismatches;
  assign pending_o = waiting;

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH %s", $time, what);
    mismatches++;
  endtask

  function automatic int packet_limit();
    if (reg_total == 0) return 1;
    if (reg_total > MAX_PACKETS) return MAX_PACKETS;
    return int'(reg_total);
  endfunction

  function automatic result_t make_reply(input kind_e k, input logic [SEQ_W-1:0] s);
    result_t r;
    r.kind  = k;
    r.seq   = s;
    r.base  = base_q;
    r.bytes = bytes_q;
    r.last  = 1'b0;
    return r;
  endfunction

  task automatic predict_replies(input logic op, input logic [SEQ_W-1:0] seq,
                                 input logic [LEN_W-1:0] len, input logic crc,
                                 input logic sess);
    result_t          batch [3];
    int               n;
    int               lim;
    logic [LEN_W-1:0] want_len;
    logic [BYTES_W:0] sum;
    n   = 0;
    lim = packet_limit();
    if (op) begin
      if (nack_timer != TIMER_SAT) nack_timer++;
      return;
    end
    if (finished_q || !sess) return;
    if (seq >= lim || len == 0 || len > reg_full) return;
    want_len = (seq == lim - 1) ? reg_last_len : reg_full;
    if (len != want_len) return;
    if (!crc) begin
      batch[0] = make_reply(KIND_NACK, seq);
      n = 1;
    end else begin
      if (!seen_map[seq]) begin
        seen_map[seq] = 1'b1;
        unique_q++;
        sum = bytes_q + len;
        bytes_q = sum[BYTES_W] ? '1 : sum[BYTES_W-1:0];
        if (seq > highest_q) highest_q = seq[$clog2(MAX_PACKETS)-1:0];
        while (int'(base_q) < lim && seen_map[base_q]) base_q++;
      end
      batch[0] = make_reply(KIND_ACK, seq);
      n = 1;
      if (int'(base_q) < lim && base_q <= highest_q && !seen_map[base_q] &&
          nack_timer >= reg_gap) begin
        batch[n] = make_reply(KIND_NACK, SEQ_W'(base_q));
        n++;
        nack_timer = '0;
      end
      if (unique_q >= lim) begin
        batch[n] = make_reply(KIND_DONE, '0);
        n++;
        finished_q = 1'b1;
      end
    end
    batch[n-1].last = 1'b1;
    for (int k = 0; k < n; k++) due_replies.push_back(batch[k]);
  endtask

  task automatic check_reply();
    result_t want;
    if (due_replies.size() == 0) begin
      report_mismatch($sformatf("unexpected reply kind %0d seq %0d base %0d", kind_i,
                                seq_number_i, window_base_i));
      return;
    end
    want = due_replies.pop_front();
    if (kind_i != want.kind || seq_number_i != want.seq || window_base_i != want.base ||
        bytes_total_i != want.bytes || last_i != want.last)
      report_mismatch($sformatf(
        "kind/seq/base/bytes/last got %0d %0d %0d %0d %0d want %0d %0d %0d %0d %0d",
        kind_i, seq_number_i, window_base_i, bytes_total_i, last_i,
        want.kind, want.seq, want.base, want.bytes, want.last));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (seen_map[k]) seen_map[k] = 1'b0;
      base_q       = '0;
      highest_q    = '0;
      unique_q     = '0;
      bytes_q      = '0;
      nack_timer   = TIMER_SAT;
      finished_q   = 1'b0;
      reg_total    = TOTAL_RST;
      reg_full     = FULL_RST;
      reg_last_len = FINAL_RST;
      reg_gap      = GAP_RST;
      due_replies.delete();
    end else begin
      if (out_valid_i && out_ready_i) check_reply();
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_TOTAL: reg_total    = cfg_data_i[TOTAL_W-1:0];
          CFG_FULL:  reg_full     = cfg_data_i;
          CFG_FINAL: reg_last_len = cfg_data_i;
          CFG_GAP:   reg_gap      = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i)
        predict_replies(operation_i, seq_in_i, length_in_i, crc_ok_i, session_ok_i);
    end
    waiting = due_replies.size();
  end

endmodule

### tb/sv/tb.sv
// Top of the receive tracker testbench: clock, reset, register writes, item stimulus
// and result back-pressure; srt_checker does the prediction and comparison.
// Depends on srt_pkg, srt_checker and selective_repeat_receive_tracker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import srt_pkg::*;

  localparam int MAX_PACKETS = 4096;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic                 operation_i = 1'b0;
  logic [SEQ_W-1:0]     seq_in_i = '0;
  logic [LEN_W-1:0]     length_in_i = '0;
  logic                 crc_ok_i = 1'b0;
  logic                 session_ok_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [1:0]           kind_o;
  logic [SEQ_W-1:0]     seq_number_o;
  logic [WIN_W-1:0]     window_base_o;
  logic [BYTES_W-1:0]   bytes_total_o;
  logic                 last_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  cfg_idx_e             cfg_index_i = CFG_TOTAL;
  logic [CFG_DAT_W-1:0] cfg_data_i = '0;
  int                   errors;
  int                   pending;

  int                   lim_now = 1;
  logic [LEN_W-1:0]     full_now = FULL_RST;
  logic [LEN_W-1:0]     last_now = FINAL_RST;
  bit                   sent_good [MAX_PACKETS];
  int                   cursor = 0;
  bit                   calm = 1'b0;
  int                   stall_left = 0;

  selective_repeat_receive_tracker #(.MAX_PACKETS(MAX_PACKETS)) dut (.*);

  srt_checker #(.MAX_PACKETS(MAX_PACKETS)) checker_i (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .operation_i, .seq_in_i, .length_in_i,
    .crc_ok_i, .session_ok_i,
    .out_valid_i(out_valid_o), .out_ready_i, .kind_i(kind_o), .seq_number_i(seq_number_o),
    .window_base_i(window_base_o), .bytes_total_i(bytes_total_o), .last_i(last_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .errors_o(errors), .pending_o(pending)
  );

  always #5 clk_i = ~clk_i;

  function automatic int draw_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else begin
      out_ready_i <= 1'b1;
      stall_left = draw_gap();
    end
  end

  task automatic send_item(input logic op, input logic [SEQ_W-1:0] seq,
                           input logic [LEN_W-1:0] len, input logic crc, input logic sess);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    operation_i  <= op;
    seq_in_i     <= seq;
    length_in_i  <= len;
    crc_ok_i     <= crc;
    session_ok_i <= sess;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic send_packet(input int seq, input logic crc);
    logic [LEN_W-1:0] len;
    len = (seq == lim_now - 1) ? last_now : full_now;
    send_item(1'b0, seq[SEQ_W-1:0], len, crc, 1'b1);
    if (crc && len <= full_now && seq < lim_now) sent_good[seq] = 1'b1;
  endtask

  task automatic send_tick();
    send_item(1'b1, SEQ_W'($urandom_range(0, 65535)), LEN_W'($urandom_range(0, 65535)),
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  task automatic write_reg(input cfg_idx_e idx, input int value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value[CFG_DAT_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  task automatic start_session(input int total, input int full, input int last_len,
                               input int gap);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (64) @(negedge clk_i);
    write_reg(CFG_TOTAL, total);
    write_reg(CFG_FULL, full);
    write_reg(CFG_FINAL, last_len);
    write_reg(CFG_GAP, gap);
    cfg_valid_i <= 1'b0;
    lim_now  = (total == 0) ? 1 : ((total > MAX_PACKETS) ? MAX_PACKETS : total);
    full_now = LEN_W'(full);
    last_now = LEN_W'(last_len);
  endtask

  function automatic int pick_seq();
    int s;
    s = cursor - 4 + $urandom_range(0, 7);
    if (s < 0) s = 0;
    if (s > lim_now - 2) s = lim_now - 2;
    return s;
  endfunction

  task automatic run_random(input int n);
    int r;
    int s;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 18) begin
        send_tick();
      end else if (r < 26) begin
        send_item(1'b0, SEQ_W'($urandom_range(0, 65535)), LEN_W'($urandom_range(0, 65535)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else if (r < 32) begin
        s = pick_seq();
        case ($urandom_range(0, 4))
          0: send_item(1'b0, SEQ_W'(s), full_now, 1'b1, 1'b0);
          1: send_item(1'b0, SEQ_W'(s), full_now + 16'd1, 1'b1, 1'b1);
          2: send_item(1'b0, SEQ_W'(s), full_now - 16'd1, 1'b1, 1'b1);
          3: send_item(1'b0, SEQ_W'(s), '0, 1'b1, 1'b1);
          default: send_item(1'b0, SEQ_W'($urandom_range(lim_now, 65535)), full_now, 1'b1,
                             1'b1);
        endcase
      end else if (r < 40) begin
        send_packet(pick_seq(), 1'b0);
      end else if (r < 44) begin
        send_packet(lim_now - 1, 1'b1);
      end else begin
        send_packet(pick_seq(), 1'b1);
        cursor += $urandom_range(0, 1);
        if (cursor > lim_now - 2) cursor = lim_now - 2;
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    int got_count;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    start_session(4096, 256, 65535, 0);
    send_tick();
    send_packet(0, 1'b0);
    send_item(1'b0, 16'd0, 16'd256, 1'b1, 1'b0);
    send_item(1'b0, 16'd0, 16'd0, 1'b1, 1'b1);
    send_item(1'b0, 16'd0, 16'd65535, 1'b1, 1'b1);
    send_item(1'b0, 16'd65535, 16'd256, 1'b1, 1'b1);
    send_item(1'b0, 16'd4095, 16'd65535, 1'b1, 1'b1);
    send_item(1'b0, 16'd4095, 16'd256, 1'b1, 1'b1);
    send_packet(0, 1'b1);
    send_packet(0, 1'b1);
    send_packet(3, 1'b1);
    send_packet(2, 1'b1);
    send_packet(1, 1'b0);
    send_packet(1, 1'b1);
    send_tick();
    send_tick();
    send_item(1'b0, 16'd65535, 16'd65535, 1'b1, 1'b0);
    send_item(1'b1, 16'd65535, 16'd65535, 1'b1, 1'b1);
    cursor = 4;
    run_random(100);

    start_session(1000, 65535, 1, 3);
    run_random(110);

    start_session(8191, 700, 300, 65535);
    run_random(110);

    start_session(4096, 1024, 1024, 7);
    run_random(110);

    start_session(0, 1024, 100, 0);
    send_packet(0, 1'b0);
    send_item(1'b0, 16'd0, 16'd1024, 1'b1, 1'b1);
    send_item(1'b0, 16'd1, 16'd100, 1'b1, 1'b1);
    send_tick();

    got_count = 0;
    foreach (sent_good[k]) if (sent_good[k]) got_count++;
    start_session(got_count, 512, 512, 0);
    send_packet(got_count - 1, 1'b1);
    send_packet(0, 1'b1);
    send_tick();
    send_packet(got_count - 1, 1'b0);

    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (64) @(negedge clk_i);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #5000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
